// ----- hw/rtl/bitmap_block_allocator_defines.svh -----
// assertion macros shared by the allocator rtl
// expects clk and rst_n to be visible where the macros are used
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define BBA_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is asserted
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bba_pkg.sv -----
// types and constants for the bitmap block allocator
// no dependencies
package bba_pkg;

  localparam int OP_W       = 1;
  localparam int BN_W       = 12;
  localparam int STAT_W     = 2;
  localparam int DS_W       = 12;
  localparam int TB_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [TB_W-1:0] TB_RESET = 13'd4096;

  localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL        = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DOUBLE_FREE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_EXAM,
    ST_RESP
  } bba_state_t;

endpackage

// ----- hw/rtl/bitmap_block_allocator.sv -----
// bitmap block allocator: allocation map in a single-port-write memory, scanned word by word
// depends on bba_pkg and bitmap_block_allocator_defines.svh
//
//   channel | signals                                      | direction
//   in      | in_valid in_ready in_operation in_block_number | request
//   out     | out_valid out_ready out_block_number_res out_status | response
//   cfg     | cfg_we cfg_index cfg_wdata                     | register write
//
// after reset a clearing pass writes every map word with in_ready low
// per transaction: an accept in ST_IDLE, a walk in ST_LOCATE word by word to the target word, then its read,
// then ST_EXAM examines map words (one read per cycle), a free only its target, then ST_RESP responds
// worst case an allocate or a free passes over every map word, plus any out_ready stall
// the next request is taken while the response register still waits for out_ready
`include "bitmap_block_allocator_defines.svh"

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS    = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bba_pkg::OP_W-1:0]      in_operation,
  input  logic [bba_pkg::BN_W-1:0]      in_block_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::BN_W-1:0]      out_block_number_res,
  output logic [bba_pkg::STAT_W-1:0]    out_status,
  input  logic                          cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int PW_MIN    = $clog2(MAX_BLOCKS + MAP_WORD_BITS + 1);
  localparam int PW        = (PW_MIN > TB_W) ? PW_MIN : TB_W + 1;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OW        = $clog2(MAP_WORD_BITS);

  localparam logic [WA_W-1:0]   LAST_WORD = WA_W'(MAP_WORDS - 1);
  localparam logic [PW-1:0]     WORD_STEP = PW'(MAP_WORD_BITS);
  localparam logic [PW-1:0]     MAXB_EXT  = PW'(MAX_BLOCKS);
  localparam logic [OW:0]       WORD_SPAN = (OW + 1)'(MAP_WORD_BITS);

  // configuration registers
  logic [DS_W-1:0] data_start_r;
  logic [TB_W-1:0] total_blocks_r;

  // sequencer state
  bba_state_t          state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [BN_W-1:0]     bn_r, bn_nxt;
  logic [WA_W-1:0]     w_r, w_nxt;
  logic [PW-1:0]       base_r, base_nxt;
  logic [PW-1:0]       limit_r, limit_nxt;
  logic [BN_W-1:0]     res_r, res_nxt;
  logic [STAT_W-1:0]   stat_r, stat_nxt;
  logic [WA_W-1:0]     clr_r, clr_nxt;

  // response register
  logic                out_valid_r, out_valid_nxt;
  logic [BN_W-1:0]     out_bn_r, out_bn_nxt;
  logic [STAT_W-1:0]   out_st_r, out_st_nxt;

  // map memory
  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORD_BITS-1:0] map_rd_r;
  logic                     mem_we, mem_re;
  logic [WA_W-1:0]          mem_wa, mem_ra;
  logic [MAP_WORD_BITS-1:0] mem_wd;

  // datapath helpers
  logic [PW-1:0]            ds_ext, tb_ext, lim_eff, bn_in_ext, bn_ext, target, base_end;
  logic [PW-1:0]            lo_diff, hi_diff, hit_pos, free_diff, out_bn_ext;
  logic [OW:0]              lo, hi;
  logic [OW-1:0]            free_off, hit_off;
  logic [MAP_WORD_BITS-1:0] avail, free_mask, hit_mask;
  logic                     hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r   <= '0;
      total_blocks_r <= TB_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_START:   data_start_r   <= cfg_wdata[DS_W-1:0];
        CFG_TOTAL_BLOCKS: total_blocks_r <= cfg_wdata[TB_W-1:0];
        default: ;
      endcase
    end
  end

  assign ds_ext    = PW'(data_start_r);
  assign tb_ext    = PW'(total_blocks_r);
  assign lim_eff   = (tb_ext > MAXB_EXT) ? MAXB_EXT : tb_ext;
  assign bn_in_ext = PW'(in_block_number);
  assign bn_ext    = PW'(bn_r);
  assign target    = (op_r == OP_FREE) ? bn_ext : ds_ext;
  assign base_end  = base_r + WORD_STEP;

  // bit of the word being freed
  assign free_diff = bn_ext - base_r;
  assign free_off  = free_diff[OW-1:0];
  assign free_mask = MAP_WORD_BITS'(1) << free_off;

  // window of the current word that allocation may use
  assign lo_diff = ds_ext - base_r;
  assign hi_diff = limit_r - base_r;
  assign lo      = (ds_ext > base_r) ? lo_diff[OW:0] : '0;
  assign hi      = (hi_diff >= WORD_STEP) ? WORD_SPAN : hi_diff[OW:0];

  always_comb begin
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      avail[j] = !map_rd_r[j] && ((OW + 1)'(j) >= lo) && ((OW + 1)'(j) < hi);
    end
  end

  // lowest free bit in the window
  always_comb begin
    hit     = 1'b0;
    hit_off = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        hit     = 1'b1;
        hit_off = OW'(j);
      end
    end
  end

  assign hit_mask = MAP_WORD_BITS'(1) << hit_off;
  assign hit_pos  = base_r + PW'(hit_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    bn_r     <= bn_nxt;
    w_r      <= w_nxt;
    base_r   <= base_nxt;
    limit_r  <= limit_nxt;
    res_r    <= res_nxt;
    stat_r   <= stat_nxt;
    out_bn_r <= out_bn_nxt;
    out_st_r <= out_st_nxt;
  end

  // writes and reads never touch the same word in one cycle: a write ends a transaction
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    if (mem_re) map_rd_r <= map_mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bn_nxt        = bn_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    limit_nxt     = limit_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_bn_nxt    = out_bn_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = w_r;
    mem_wd        = map_rd_r;
    mem_re        = 1'b0;
    mem_ra        = w_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = in_operation;
          bn_nxt    = in_block_number;
          limit_nxt = lim_eff;
          w_nxt     = '0;
          base_nxt  = '0;
          res_nxt   = '0;
          state_nxt = ST_LOCATE;
          if (in_operation == OP_FREE && bn_in_ext >= lim_eff) begin
            stat_nxt  = STAT_RANGE;
            state_nxt = ST_RESP;
          end else if (in_operation == OP_ALLOC && ds_ext >= lim_eff) begin
            stat_nxt  = STAT_FULL;
            state_nxt = ST_RESP;
          end
        end
      end
      ST_LOCATE: begin
        // walk to the word that holds the target block
        if (target < base_end) begin
          mem_re    = 1'b1;
          mem_ra    = w_r;
          state_nxt = ST_EXAM;
        end else begin
          w_nxt    = w_r + 1'b1;
          base_nxt = base_end;
        end
      end
      ST_EXAM: begin
        if (op_r == OP_FREE) begin
          if (!map_rd_r[free_off]) begin
            stat_nxt = STAT_DOUBLE_FREE;
          end else begin
            mem_we   = 1'b1;
            mem_wd   = map_rd_r & ~free_mask;
            stat_nxt = STAT_OK;
          end
          state_nxt = ST_RESP;
        end else if (hit) begin
          mem_we    = 1'b1;
          mem_wd    = map_rd_r | hit_mask;
          res_nxt   = hit_pos[BN_W-1:0];
          stat_nxt  = STAT_OK;
          state_nxt = ST_RESP;
        end else if (base_end >= limit_r) begin
          stat_nxt  = STAT_FULL;
          state_nxt = ST_RESP;
        end else begin
          // fetch the next word, data lands next cycle
          w_nxt    = w_r + 1'b1;
          base_nxt = base_end;
          mem_re   = 1'b1;
          mem_ra   = w_r + 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_bn_nxt    = res_r;
          out_st_nxt    = stat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_block_number_res = out_bn_r;
  assign out_status           = out_st_r;
  assign out_bn_ext           = PW'(out_bn_r);

  `BBA_ASSERT_HOLDS(a_write_state, mem_we, (state_r == ST_CLEAR) || (state_r == ST_EXAM), "map written outside clear or examine")
  `BBA_ASSERT_HOLDS(a_exam_after_read, state_r == ST_EXAM, $past(mem_re), "examine without a read issued the cycle before")
  `BBA_ASSERT_HOLDS(a_fail_zero, out_valid_r && (out_st_r != STAT_OK), out_bn_r == '0, "failed transaction returns nonzero block")
  `BBA_ASSERT_HOLDS(a_alloc_in_range, out_valid_r && (out_st_r == STAT_OK) && (out_bn_r != '0), out_bn_ext < limit_r, "allocated block past the block limit")
  `BBA_ASSERT_NEXT(a_resp_loads, (state_r == ST_RESP) && (!out_valid_r || out_ready), out_valid_r && (state_r == ST_IDLE), "response not loaded into output register")

endmodule
